[design/ple_pkg.sv]
// Package for the positional list engine: request and result structs,
// operation and status codes, and default sizes. No dependencies.
package ple_pkg;

  localparam int CAPACITY_DEFAULT  = 64;
  localparam int WORD_BITS_DEFAULT = 32;

  // Fixed field widths of the request and result.
  localparam int REQ_TYPE_BITS = 3;
  localparam int POS_BITS      = 7;
  localparam int VALUE_BITS    = 32;
  localparam int LEN_BITS      = 7;
  localparam int STATUS_BITS   = 2;

  localparam logic [REQ_TYPE_BITS-1:0] OP_INSERT = 3'd0;
  localparam logic [REQ_TYPE_BITS-1:0] OP_DELETE = 3'd1;
  localparam logic [REQ_TYPE_BITS-1:0] OP_MODIFY = 3'd2;
  localparam logic [REQ_TYPE_BITS-1:0] OP_READ   = 3'd3;
  localparam logic [REQ_TYPE_BITS-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [REQ_TYPE_BITS-1:0]   req_type;
    logic [POS_BITS-1:0]        position;
    logic signed [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] read_value;
    logic [LEN_BITS-1:0]        list_length;
    logic                       list_empty;
    logic [STATUS_BITS-1:0]     status;
  } res_t;

endpackage

[design/positional_list_engine_core.sv]
// Positional list engine: ordered list of signed words held in a row of cells.
// A request is held in the request stage, then its result in the result register.
// Throughput: one request per cycle while results are taken; every cell shifts
// in parallel under a compare of its index with the requested position, and the
// result register lets a new request enter while a result waits to be taken.
// Reset: synchronous, active high; empties the list and both stages. Cell
// contents are not reset and are only read after being written.
module positional_list_engine_core #(
  parameter int CAPACITY  = ple_pkg::CAPACITY_DEFAULT,
  parameter int WORD_BITS = ple_pkg::WORD_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ple_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output ple_pkg::res_t res
);
  import ple_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Request stage.
  logic                 held_valid;
  req_t                 held;
  logic                 advance;

  // List state.
  logic [WORD_BITS-1:0] entries [CAPACITY];
  logic [CNT_W-1:0]     count;

  // Decode of the held request.
  logic [CMP_W-1:0]     pos_x;
  logic [CMP_W-1:0]     pos_m1;
  logic [CMP_W-1:0]     cnt_x;
  logic [CMP_W-1:0]     cnt_x_next;
  logic [CNT_W-1:0]     count_next;
  logic [IDX_W-1:0]     idx;
  logic [WORD_BITS-1:0] wr_word;
  logic [WORD_BITS-1:0] rd_word;
  logic [VALUE_BITS-1:0] rd_ext;
  logic [VALUE_BITS-1:0] rd_value;
  logic [STATUS_BITS-1:0] status_calc;
  logic                 do_insert;
  logic                 do_delete;
  logic                 do_write;
  logic                 take_read;

  assign advance   = held_valid && (!res_valid || res_ready);
  assign req_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req_ready) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      held <= req;
    end
  end

  generate
    if (WORD_BITS > VALUE_BITS) begin : g_wr_wide
      assign wr_word = {{(WORD_BITS - VALUE_BITS){1'b0}}, held.value};
    end else begin : g_wr_narrow
      assign wr_word = held.value[WORD_BITS-1:0];
    end
    if (WORD_BITS >= VALUE_BITS) begin : g_rd_wide
      assign rd_ext = rd_word[VALUE_BITS-1:0];
    end else begin : g_rd_narrow
      assign rd_ext = {{(VALUE_BITS - WORD_BITS){1'b0}}, rd_word};
    end
  endgenerate

  assign pos_x   = CMP_W'(held.position);
  assign pos_m1  = pos_x - 1'b1;
  assign cnt_x   = CMP_W'(count);
  assign idx     = pos_m1[IDX_W-1:0];
  assign rd_word = entries[idx];

  always_comb begin
    status_calc = ST_DONE;
    do_insert   = 1'b0;
    do_delete   = 1'b0;
    do_write    = 1'b0;
    take_read   = 1'b0;
    cnt_x_next  = cnt_x;
    unique case (held.req_type)
      OP_INSERT: begin
        // Valid insert positions run from 1 to one past the last entry.
        if (pos_x == '0 || pos_m1 > cnt_x) begin
          status_calc = ST_BAD_POS;
        end else if (count == CAP_CNT) begin
          status_calc = ST_FULL;
        end else begin
          do_insert  = 1'b1;
          cnt_x_next = cnt_x + 1'b1;
        end
      end
      OP_DELETE, OP_MODIFY, OP_READ: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          status_calc = ST_BAD_POS;
        end else if (held.req_type == OP_DELETE) begin
          do_delete  = 1'b1;
          take_read  = 1'b1;
          cnt_x_next = cnt_x - 1'b1;
        end else if (held.req_type == OP_MODIFY) begin
          do_write = 1'b1;
        end else begin
          take_read = 1'b1;
        end
      end
      OP_CLEAR: begin
        cnt_x_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign count_next = cnt_x_next[CNT_W-1:0];
  assign rd_value   = take_read ? rd_ext : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (advance) begin
      count <= count_next;
    end
  end

  // Each cell looks only at its neighbors and its own index compare.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_insert) begin
          if (IDX_W'(i) == idx) begin
            entries[i] <= wr_word;
          end else if (i > 0 && IDX_W'(i) > idx) begin
            entries[i] <= entries[(i > 0) ? i - 1 : 0];
          end
        end else if (do_delete) begin
          if (i < CAPACITY - 1 && IDX_W'(i) >= idx) begin
            entries[i] <= entries[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end else if (do_write) begin
          if (IDX_W'(i) == idx) begin
            entries[i] <= wr_word;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.read_value  <= rd_value;
      res.list_length <= cnt_x_next[LEN_BITS-1:0];
      res.list_empty  <= (count_next == '0);
      res.status      <= status_calc;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("list count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    advance && do_insert |=> count == $past(count) + 1'b1)
    else $error("successful insert did not grow the list by one");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    advance && held.req_type == OP_CLEAR |=> count == '0 && res_valid && res.list_empty)
    else $error("clear did not empty the list");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("processed request produced no result");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for positional_list_engine_core: directed and random list
// requests, predicted against a local model of the list. Depends on ple_pkg.
module testbench;
  import ple_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic res_valid;
  logic res_ready;
  res_t res;

  // Predicted contents of the list and the results still owed by the block.
  logic signed [VALUE_BITS-1:0] list_words [CAPACITY_DEFAULT];
  int   list_len;
  res_t pending_results [$];
  int   mismatches;
  int   burst_left;
  bit   hold_req;
  bit   holding;

  positional_list_engine_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the predicted list and returns the result it should give.
  function automatic res_t apply_request(req_t r);
    res_t out;
    int   p;
    int   i;
    p   = int'(r.position);
    out = '0;
    out.status = ST_DONE;
    case (r.req_type)
      OP_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          out.status = ST_BAD_POS;
        end else if (list_len >= CAPACITY_DEFAULT) begin
          out.status = ST_FULL;
        end else begin
          for (i = list_len; i > p - 1; i--) list_words[i] = list_words[i-1];
          list_words[p-1] = r.value;
          list_len++;
        end
      end
      OP_DELETE, OP_MODIFY, OP_READ: begin
        if (p < 1 || p > list_len) begin
          out.status = ST_BAD_POS;
        end else if (r.req_type == OP_DELETE) begin
          out.read_value = list_words[p-1];
          for (i = p - 1; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end else if (r.req_type == OP_MODIFY) begin
          list_words[p-1] = r.value;
        end else begin
          out.read_value = list_words[p-1];
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    out.list_length = LEN_BITS'(list_len);
    out.list_empty  = (list_len == 0);
    return out;
  endfunction

  function automatic req_t make_req(logic [REQ_TYPE_BITS-1:0] op, int pos,
                                    logic signed [VALUE_BITS-1:0] word);
    req_t r;
    r.req_type = op;
    r.position = POS_BITS'(pos);
    r.value    = word;
    return r;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] random_word();
    case ($urandom_range(9))
      0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
      1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // Mostly well-formed positions for the current length, some anywhere in the field.
  function automatic req_t random_request(int ins_pct, int del_pct, int clr_pct);
    req_t r;
    int   roll;
    int   top;
    roll    = $urandom_range(99);
    r.value = random_word();
    if (roll < 3) r.req_type = REQ_TYPE_BITS'($urandom_range(7, 5));
    else if (roll < 3 + clr_pct) r.req_type = OP_CLEAR;
    else if (roll < 3 + clr_pct + ins_pct) r.req_type = OP_INSERT;
    else if (roll < 3 + clr_pct + ins_pct + del_pct) r.req_type = OP_DELETE;
    else r.req_type = ($urandom_range(1) == 1) ? OP_MODIFY : OP_READ;
    top = (r.req_type == OP_INSERT) ? list_len + 1 : list_len;
    if ($urandom_range(9) == 0 || top == 0) r.position = POS_BITS'($urandom_range(127));
    else r.position = POS_BITS'($urandom_range(top, 1));
    return r;
  endfunction

  // The sender offers requests in bursts; valid stays high between requests of a burst.
  task automatic send_request(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pending_results.push_back(apply_request(r));
  endtask

  task automatic wait_for_results;
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list;
    send_request(make_req(OP_DELETE, 1, '0));
    send_request(make_req(OP_READ, 1, '0));
    send_request(make_req(OP_MODIFY, 1, 32'sd5));
    send_request(make_req(OP_INSERT, 0, 32'sd7));
    send_request(make_req(OP_INSERT, 2, 32'sd7));
    send_request(make_req(OP_INSERT, 127, 32'sd7));
    send_request(make_req(OP_CLEAR, 0, '0));
  endtask

  task automatic test_basic_ops;
    send_request(make_req(OP_INSERT, 1, 32'sh7fff_ffff));
    send_request(make_req(OP_INSERT, 1, 32'sh8000_0000));
    send_request(make_req(OP_INSERT, 3, '0));
    send_request(make_req(OP_INSERT, 2, '1));
    send_request(make_req(OP_READ, 1, '0));
    send_request(make_req(OP_READ, 4, '0));
    send_request(make_req(OP_READ, 5, '0));
    send_request(make_req(OP_READ, 0, '0));
    send_request(make_req(OP_MODIFY, 2, 32'sh1234_5678));
    send_request(make_req(OP_READ, 2, '0));
    send_request(make_req(OP_DELETE, 1, '0));
    send_request(make_req(OP_DELETE, 3, '0));
    send_request(make_req(OP_DELETE, 3, '0));
    // Unknown request types leave the list alone.
    send_request(make_req(3'd5, 1, 32'sd1));
    send_request(make_req(3'd6, 2, 32'sd2));
    send_request(make_req(3'd7, 127, '1));
    send_request(make_req(OP_CLEAR, 127, '1));
  endtask

  task automatic test_full_list;
    while (list_len < CAPACITY_DEFAULT)
      send_request(make_req(OP_INSERT, $urandom_range(list_len + 1, 1), random_word()));
    // Position 65 is legal for insert but the list is full; 66 fails the position check first.
    send_request(make_req(OP_INSERT, CAPACITY_DEFAULT + 1, 32'sd3));
    send_request(make_req(OP_INSERT, CAPACITY_DEFAULT + 2, 32'sd3));
    send_request(make_req(OP_INSERT, 1, 32'sd3));
    send_request(make_req(OP_READ, CAPACITY_DEFAULT, '0));
    send_request(make_req(OP_READ, CAPACITY_DEFAULT + 1, '0));
    send_request(make_req(OP_MODIFY, CAPACITY_DEFAULT, 32'sh5a5a_a5a5));
    send_request(make_req(OP_DELETE, CAPACITY_DEFAULT, '0));
    send_request(make_req(OP_DELETE, 1, '0));
    send_request(make_req(OP_INSERT, CAPACITY_DEFAULT - 1, 32'sd9));
  endtask

  // The receiver stops for a long stretch while requests keep coming.
  task automatic test_backpressure;
    int n;
    hold_req = 1'b1;
    for (n = 0; n < 40; n++) send_request(random_request(35, 30, 2));
    wait_for_results();
    for (n = 0; n < 20; n++) send_request(random_request(35, 30, 2));
  endtask

  task automatic test_random_traffic;
    int   accepted;
    int   phase_left;
    int   ins;
    int   del;
    int   clr;
    req_t r;
    accepted   = 0;
    phase_left = 0;
    ins = 35;
    del = 30;
    clr = 2;
    while (accepted < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 200);
        case ($urandom_range(2))
          0: begin ins = 60; del = 15; clr = 0; end
          1: begin ins = 15; del = 55; clr = 1; end
          default: begin ins = 35; del = 30; clr = 2; end
        endcase
      end
      r = random_request(ins, del, clr);
      send_request(r);
      if (r.req_type <= OP_CLEAR) begin
        accepted++;
        phase_left--;
      end
    end
  endtask

  initial begin : hold_off
    holding = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end
    end
  end

  // The receiver switches between always ready and several stall patterns.
  initial begin : result_sink
    int mode;
    int left;
    mode = 0;
    left = 0;
    res_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(3);
        left = $urandom_range(20, 200);
      end
      left--;
      if (holding) begin
        res_ready <= 1'b0;
      end else begin
        case (mode)
          0: res_ready <= 1'b1;
          1: res_ready <= ($urandom_range(1) == 1);
          2: res_ready <= ($urandom_range(3) == 0);
          default: res_ready <= ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: value %0d length %0d empty %0b status %0d",
                   res.read_value, res.list_length, res.list_empty, res.status);
      end else begin
        want = pending_results.pop_front();
        if (res.read_value !== want.read_value || res.list_length !== want.list_length ||
            res.list_empty !== want.list_empty || res.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result mismatch: expected value %0d length %0d empty %0b status %0d",
                     want.read_value, want.list_length, want.list_empty, want.status);
            $display("                 got value %0d length %0d empty %0b status %0d",
                     res.read_value, res.list_length, res.list_empty, res.status);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    list_len   = 0;
    burst_left = 0;
    mismatches = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_backpressure();
    test_random_traffic();

    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
